// ----- hw/rtl/mvt_pkg.sv -----
package mvt_pkg;

  // Command codes of the input channel
  localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
  localparam logic [1:0] CMD_VEC4     = 2'd1;
  localparam logic [1:0] CMD_POINT    = 2'd2;

  // Matrix rows, vector elements and result lanes
  localparam int unsigned N_LANES = 4;

  // Width of every channel field that carries a Q16.16 element
  localparam int unsigned FIELD_W = 32;

  // Per-stage advance enables, shared by the lanes and the merge stage
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } mvt_adv_t;

endpackage

// ----- hw/rtl/mvt_if.sv -----
interface mvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [1:0]                          row_index;
  logic signed [mvt_pkg::FIELD_W-1:0]  elem_a;
  logic signed [mvt_pkg::FIELD_W-1:0]  elem_b;
  logic signed [mvt_pkg::FIELD_W-1:0]  elem_c;
  logic signed [mvt_pkg::FIELD_W-1:0]  elem_d;

  modport source (
    output valid, command, row_index, elem_a, elem_b, elem_c, elem_d,
    input  ready
  );
  modport sink (
    input  valid, command, row_index, elem_a, elem_b, elem_c, elem_d,
    output ready
  );
endinterface

interface mvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvt_pkg::FIELD_W-1:0]  out_x;
  logic signed [mvt_pkg::FIELD_W-1:0]  out_y;
  logic signed [mvt_pkg::FIELD_W-1:0]  out_z;
  logic signed [mvt_pkg::FIELD_W-1:0]  out_w;
  logic                                w_valid;
  logic                                saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, w_valid, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, w_valid, saturated,
    output ready
  );
endinterface

// ----- hw/rtl/mvt_matrix.sv -----
module mvt_matrix #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned IN_W       = 32
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            wr_en,
  input  logic [1:0]                                      wr_row,
  input  logic [mvt_pkg::N_LANES-1:0][IN_W-1:0]           wr_data,
  output logic [mvt_pkg::N_LANES-1:0][mvt_pkg::N_LANES-1:0][IN_W-1:0] mat
);

  // 1.0 in fixed point, clipped to the largest element when it does not fit
  localparam bit ONE_FITS = (FRAC_BITS < IN_W - 1);
  localparam logic [IN_W-1:0] ONE_V =
    ONE_FITS ? (IN_W'(1) << FRAC_BITS) : {1'b0, {(IN_W-1){1'b1}}};

  logic [mvt_pkg::N_LANES-1:0][mvt_pkg::N_LANES-1:0][IN_W-1:0] mat_r;

  // Reset to identity, overwrite one row on a load transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < mvt_pkg::N_LANES; r++) begin
        for (int c = 0; c < mvt_pkg::N_LANES; c++) begin
          mat_r[r][c] <= (r == c) ? ONE_V : '0;
        end
      end
    end else if (wr_en) begin
      mat_r[wr_row] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

// ----- hw/rtl/mvt_lane.sv -----
module mvt_lane #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned IN_W       = 32
) (
  input  logic                                  clk,
  input  mvt_pkg::mvt_adv_t                     adv,
  input  logic [mvt_pkg::N_LANES-1:0][IN_W-1:0] mat_row,
  input  logic [mvt_pkg::N_LANES-1:0][IN_W-1:0] elem,
  input  logic                                  is_point,
  output logic [ELEM_WIDTH-1:0]                 res,
  output logic                                  clip
);

  localparam int unsigned PROD_W = 2 * IN_W;
  localparam int unsigned TR_W   = IN_W + FRAC_BITS;
  localparam int unsigned ACC_W  = ((PROD_W > TR_W) ? PROD_W : TR_W) + 2;
  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned SH_W   = SUM_W - FRAC_BITS;
  localparam int unsigned EXT_W  = ((SH_W > ELEM_WIDTH) ? SH_W : ELEM_WIDTH) + 1;

  localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [ACC_W-1:0]      prod_nxt [mvt_pkg::N_LANES];
  logic signed [ACC_W-1:0]      prod_r   [mvt_pkg::N_LANES];
  logic signed [ACC_W-1:0]      pair_r   [2];
  logic signed [SUM_W-1:0]      sum_nxt;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [SH_W-1:0]       sh;
  logic signed [EXT_W-1:0]      sh_ext;
  logic [ELEM_WIDTH-1:0]        res_nxt;
  logic                         clip_nxt;
  logic [ELEM_WIDTH-1:0]        res_r;
  logic                         clip_r;
  logic signed [PROD_W-1:0]     mul [mvt_pkg::N_LANES];
  logic signed [TR_W-1:0]       trans;

  // One multiplier per column
  for (genvar c = 0; c < mvt_pkg::N_LANES; c++) begin : g_mul
    assign mul[c] = $signed(mat_row[c]) * $signed(elem[c]);
  end

  // Fourth column of a point is a plain translation: element times 1.0
  assign trans = $signed({mat_row[mvt_pkg::N_LANES-1], {FRAC_BITS{1'b0}}});

  always_comb begin
    for (int c = 0; c < mvt_pkg::N_LANES - 1; c++) begin
      prod_nxt[c] = ACC_W'(mul[c]);
    end
    prod_nxt[mvt_pkg::N_LANES-1] = is_point ? ACC_W'(trans)
                                            : ACC_W'(mul[mvt_pkg::N_LANES-1]);
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (adv.en1) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 2: pair sums
  always_ff @(posedge clk) begin
    if (adv.en2) begin
      pair_r[0] <= prod_r[0] + prod_r[1];
      pair_r[1] <= prod_r[2] + prod_r[3];
    end
  end

  // Stage 3: total plus half an LSB for round to nearest
  assign sum_nxt = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + RND;

  always_ff @(posedge clk) begin
    if (adv.en3) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage 4: shift back and saturate
  assign sh     = $signed(sum_r[SUM_W-1:FRAC_BITS]);
  assign sh_ext = EXT_W'(sh);

  always_comb begin
    clip_nxt = 1'b0;
    res_nxt  = sh_ext[ELEM_WIDTH-1:0];
    if (sh_ext > SAT_MAX) begin
      clip_nxt = 1'b1;
      res_nxt  = SAT_MAX[ELEM_WIDTH-1:0];
    end else if (sh_ext < SAT_MIN) begin
      clip_nxt = 1'b1;
      res_nxt  = SAT_MIN[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en4) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res  = res_r;
  assign clip = clip_r;

endmodule

// ----- hw/rtl/mvt_merge.sv -----
module mvt_merge #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                                        clk,
  input  mvt_pkg::mvt_adv_t                           adv,
  input  logic [mvt_pkg::N_LANES-1:0][ELEM_WIDTH-1:0] lane_res,
  input  logic [mvt_pkg::N_LANES-1:0]                 lane_clip,
  input  logic                                        is_point,
  output logic [mvt_pkg::N_LANES-1:0][mvt_pkg::FIELD_W-1:0] comp,
  output logic                                        w_valid,
  output logic                                        saturated
);

  localparam int unsigned LAST = mvt_pkg::N_LANES - 1;

  logic [mvt_pkg::N_LANES-1:0][mvt_pkg::FIELD_W-1:0] comp_nxt;
  logic [mvt_pkg::N_LANES-1:0][mvt_pkg::FIELD_W-1:0] comp_r;
  logic                                              w_valid_r;
  logic                                              saturated_r;
  logic                                              sat_nxt;

  // Fit each lane to the field width; drop the fourth lane for points
  always_comb begin
    for (int i = 0; i < mvt_pkg::N_LANES; i++) begin
      comp_nxt[i] = mvt_pkg::FIELD_W'($signed(lane_res[i]));
    end
    if (is_point) begin
      comp_nxt[LAST] = '0;
    end
    sat_nxt = (|lane_clip[LAST-1:0]) | (lane_clip[LAST] & ~is_point);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv.en5) begin
      comp_r      <= comp_nxt;
      w_valid_r   <= ~is_point;
      saturated_r <= sat_nxt;
    end
  end

  assign comp      = comp_r;
  assign w_valid   = w_valid_r;
  assign saturated = saturated_r;

endmodule

// ----- hw/rtl/matrix4_vector_transform.sv -----
// 4x4 matrix times vector in signed fixed point (Q16.16 at the defaults).
// in_ch carries a command, a row index and four elements. A load-row
// transfer writes one matrix row and gives no result; the unused command
// code is dropped without a result. A four-vector transfer returns M*v; a
// point transfer treats the fourth element as 1.0, returns x, y, z with
// out_w zero and w_valid low. Each component is rounded to nearest, shifted
// back and saturated; saturated flags any clipped component.
// Throughput: one item per clock while out_ch does not stall, as every lane
// has its own multiplier per column and each of the five stages is a plain
// register. Pipeline: five register stages (products, pair sums, total,
// saturate, output register), passed in that order; a result is presented
// on out_ch from the output register and transfers out when ready is high.
// A load row takes effect for the very next item.
// Reset (rst_n low, synchronous) restores the identity matrix and empties
// the pipeline. When out_ch stalls, the five stages fill up behind the
// held result and in_ch.ready only drops once every stage holds an item.
module matrix4_vector_transform #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  mvt_in_if.sink         in_ch,
  mvt_out_if.source      out_ch
);

  localparam int unsigned IN_W = (ELEM_WIDTH < mvt_pkg::FIELD_W) ? ELEM_WIDTH
                                                                  : mvt_pkg::FIELD_W;

  mvt_pkg::mvt_adv_t adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic pt1_r, pt2_r, pt3_r, pt4_r;
  logic in_fire;
  logic is_xform;
  logic is_load;

  logic [mvt_pkg::N_LANES-1:0][IN_W-1:0]                      elem;
  logic [mvt_pkg::N_LANES-1:0][mvt_pkg::N_LANES-1:0][IN_W-1:0] mat;
  logic [mvt_pkg::N_LANES-1:0][ELEM_WIDTH-1:0]                lane_res;
  logic [mvt_pkg::N_LANES-1:0]                                lane_clip;
  logic [mvt_pkg::N_LANES-1:0][mvt_pkg::FIELD_W-1:0]          comp;
  logic                                                       w_valid;
  logic                                                       saturated;

  // Elements are the low bits of each field
  assign elem[0] = in_ch.elem_a[IN_W-1:0];
  assign elem[1] = in_ch.elem_b[IN_W-1:0];
  assign elem[2] = in_ch.elem_c[IN_W-1:0];
  assign elem[3] = in_ch.elem_d[IN_W-1:0];

  assign is_xform = (in_ch.command == mvt_pkg::CMD_VEC4) ||
                    (in_ch.command == mvt_pkg::CMD_POINT);
  assign is_load  = (in_ch.command == mvt_pkg::CMD_LOAD_ROW);

  // Advance a stage when its successor is empty or advancing
  assign adv.en5 = ~v5_r | out_ch.ready;
  assign adv.en4 = ~v4_r | adv.en5;
  assign adv.en3 = ~v3_r | adv.en4;
  assign adv.en2 = ~v2_r | adv.en3;
  assign adv.en1 = ~v1_r | adv.en2;

  assign in_ch.ready = adv.en1;
  assign in_fire     = in_ch.valid & in_ch.ready;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv.en1) v1_r <= in_fire & is_xform;
      if (adv.en2) v2_r <= v1_r;
      if (adv.en3) v3_r <= v2_r;
      if (adv.en4) v4_r <= v3_r;
      if (adv.en5) v5_r <= v4_r;
    end
  end

  // Carry the point flag alongside the data
  always_ff @(posedge clk) begin
    if (adv.en1) pt1_r <= (in_ch.command == mvt_pkg::CMD_POINT);
    if (adv.en2) pt2_r <= pt1_r;
    if (adv.en3) pt3_r <= pt2_r;
    if (adv.en4) pt4_r <= pt3_r;
  end

  mvt_matrix #(
    .FRAC_BITS  (FRAC_BITS),
    .IN_W       (IN_W)
  ) u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire & is_load),
    .wr_row  (in_ch.row_index),
    .wr_data (elem),
    .mat     (mat)
  );

  // One lane per matrix row
  for (genvar r = 0; r < mvt_pkg::N_LANES; r++) begin : g_lane
    mvt_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .IN_W       (IN_W)
    ) u_lane (
      .clk      (clk),
      .adv      (adv),
      .mat_row  (mat[r]),
      .elem     (elem),
      .is_point (in_ch.command == mvt_pkg::CMD_POINT),
      .res      (lane_res[r]),
      .clip     (lane_clip[r])
    );
  end

  mvt_merge #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_merge (
    .clk       (clk),
    .adv       (adv),
    .lane_res  (lane_res),
    .lane_clip (lane_clip),
    .is_point  (pt4_r),
    .comp      (comp),
    .w_valid   (w_valid),
    .saturated (saturated)
  );

  assign out_ch.valid     = v5_r;
  assign out_ch.out_x     = comp[0];
  assign out_ch.out_y     = comp[1];
  assign out_ch.out_z     = comp[2];
  assign out_ch.out_w     = comp[3];
  assign out_ch.w_valid   = w_valid;
  assign out_ch.saturated = saturated;

`ifndef SYNTH
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_xform) |=> !v1_r)
    else $error("load or unused command entered the pipeline");

  a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_xform) |=> v1_r)
    else $error("transform transfer lost at pipeline entry");

  a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !adv.en4) |=> v4_r)
    else $error("blocked stage four dropped its item");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && v4_r && v5_r))
    else $error("input stalled while a pipeline stage was free");

  a_point_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.w_valid) |-> (out_ch.out_w == '0))
    else $error("point result carries a nonzero w component");
`endif

endmodule

// ----- sim/matrix4_vector_transform_tb.sv -----
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;

  // The unused command code: the block drops it without a result
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int FRAC = 16;
  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] Q_NEG_ONE = -32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [127:0] SUM_MAX  = 128'sd2147483647;
  localparam logic signed [127:0] SUM_MIN  = -128'sd2147483648;
  localparam logic signed [127:0] ROUND_HALF = 128'sd32768;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               w_valid;
    logic               saturated;
  } transform_result_t;

  logic clk;
  logic rst_n;

  mvt_in_if  in_ch ();
  mvt_out_if out_ch ();

  matrix4_vector_transform dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the matrix and the queue of transforms still to come out
  logic signed [31:0] matrix_q [16];
  transform_result_t  pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Restore the identity, as the block does on reset
  function automatic void reset_matrix();
    for (int i = 0; i < 16; i++) begin
      matrix_q[i] = (i % 5 == 0) ? Q_ONE : 32'sd0;
    end
  endfunction

  // Round half up, drop the fraction bits and clip to 32 signed bits
  function automatic logic signed [31:0] round_saturate(input logic signed [127:0] acc,
                                                        inout bit clipped);
    logic signed [127:0] shifted;
    shifted = (acc + ROUND_HALF) >>> FRAC;
    if (shifted > SUM_MAX) begin
      clipped = 1'b1;
      return Q_MAX;
    end
    if (shifted < SUM_MIN) begin
      clipped = 1'b1;
      return Q_MIN;
    end
    return shifted[31:0];
  endfunction

  // Apply one accepted transfer to the matrix mirror and queue any transform
  function automatic void predict_transfer(input logic [1:0] cmd, input logic [1:0] row,
                                           input logic signed [31:0] a, b, c, d);
    logic signed [31:0]  vec [4];
    logic signed [31:0]  comp [4];
    logic signed [127:0] acc;
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    transform_result_t   res;
    bit                  clipped;
    int                  rows;
    vec[0] = a;
    vec[1] = b;
    vec[2] = c;
    vec[3] = d;
    if (cmd == mvt_pkg::CMD_LOAD_ROW) begin
      for (int k = 0; k < 4; k++) matrix_q[int'(row) * 4 + k] = vec[k];
      return;
    end
    if (cmd != mvt_pkg::CMD_VEC4 && cmd != mvt_pkg::CMD_POINT) return;
    // a point carries an implied w of 1.0, so column four acts as translation
    if (cmd == mvt_pkg::CMD_POINT) vec[3] = Q_ONE;
    rows = (cmd == mvt_pkg::CMD_VEC4) ? 4 : 3;
    clipped = 1'b0;
    for (int r = 0; r < 4; r++) comp[r] = 32'sd0;
    for (int r = 0; r < rows; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        lhs = matrix_q[r * 4 + k];
        rhs = vec[k];
        acc += lhs * rhs;
      end
      comp[r] = round_saturate(acc, clipped);
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    res.w_valid = (cmd == mvt_pkg::CMD_VEC4);
    res.saturated = clipped;
    pending_results.push_back(res);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $error("%s: expected %h, got %h", name, exp_val, act_val);
    end
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold until transfer
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] row,
                           input logic [31:0] a, b, c, d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.row_index <= row;
    in_ch.elem_a    <= a;
    in_ch.elem_b    <= b;
    in_ch.elem_c    <= c;
    in_ch.elem_d    <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_transfer(cmd, row, a, b, c, d);
    @(negedge clk);
  endtask

  // Mostly modest Q16.16 values, with full-range noise and the extremes
  function automatic logic [31:0] rand_element();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2, 3, 4, 5: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      6: v = $urandom_range(32'h0002_0000) - 32'h0001_0000;
      7: begin
        case ($urandom_range(4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = 32'd0;
          3: v = Q_ONE;
          default: v = Q_NEG_ONE;
        endcase
      end
      8: v = 32'd1 << $urandom_range(31);
      default: v = ~(32'd1 << $urandom_range(31));
    endcase
    return v;
  endfunction

  // Send a vector and a point through the identity left by reset
  task automatic test_identity_reset();
    send_item(mvt_pkg::CMD_VEC4, 2'd2, Q_ONE, 32'shFFFD_8000, Q_MAX, Q_MIN);
    send_item(mvt_pkg::CMD_POINT, 2'd1, Q_MAX, Q_MIN, 32'sh0001_2345, 32'shDEAD_BEEF);
  endtask

  // Load extreme rows and drive the sums past both ends of the range
  task automatic test_extreme_rows();
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd2, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd3, 32'd0, 32'd0, 32'd0, Q_ONE);
    send_item(mvt_pkg::CMD_VEC4, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_item(mvt_pkg::CMD_VEC4, 2'd3, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_item(mvt_pkg::CMD_POINT, 2'd0, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
  endtask

  // Check translation, and that the fourth row neither shows nor flags on a point
  task automatic test_point_translation();
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd0, Q_ONE, 32'd0, 32'd0, 32'sh0003_0000);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd1, 32'd0, Q_ONE, 32'd0, 32'shFFFE_0000);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd2, 32'd0, 32'd0, Q_ONE, 32'sh0000_8000);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd3, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_item(mvt_pkg::CMD_POINT, 2'd2, Q_ONE, 32'sh0002_0000, 32'sh0003_0000, Q_MAX);
    send_item(mvt_pkg::CMD_VEC4, 2'd1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
  endtask

  // Exercise round-half-up on exact halves of either sign
  task automatic test_rounding();
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd0, 32'd1, 32'd0, 32'd0, 32'd0);
    send_item(mvt_pkg::CMD_LOAD_ROW, 2'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_item(mvt_pkg::CMD_VEC4, 2'd0, 32'h0000_8000, 32'd7, 32'd0, 32'd0);
    send_item(mvt_pkg::CMD_VEC4, 2'd0, 32'hFFFF_7FFF, 32'd0, 32'd0, 32'd0);
  endtask

  // The unused code must leave the matrix alone and give nothing back
  task automatic test_unused_command();
    send_item(CMD_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(mvt_pkg::CMD_VEC4, 2'd3, 32'sh0001_8000, 32'shFFFF_4000, 32'sh0000_0001,
              Q_NEG_ONE);
  endtask

  // Random mix of row loads and transforms, with a little unused-code noise
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned pick;
    logic [1:0]  cmd;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 22) cmd = mvt_pkg::CMD_LOAD_ROW;
      else if (pick < 60) cmd = mvt_pkg::CMD_VEC4;
      else if (pick < 96) cmd = mvt_pkg::CMD_POINT;
      else cmd = CMD_UNUSED;
      send_item(cmd, 2'($urandom_range(3)), rand_element(), rand_element(),
                rand_element(), rand_element());
    end
  endtask

  // Receiver: stall at random, decided at each falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transfer with the oldest outstanding transform
  always @(posedge clk) begin
    transform_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $error("result transfer with no transform outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("out_x", exp_res.x, out_ch.out_x);
        compare_field("out_y", exp_res.y, out_ch.out_y);
        compare_field("out_z", exp_res.z, out_ch.out_z);
        compare_field("out_w", exp_res.w, out_ch.out_w);
        compare_field("w_valid", 32'(exp_res.w_valid), 32'(out_ch.w_valid));
        compare_field("saturated", 32'(exp_res.saturated), 32'(out_ch.saturated));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = mvt_pkg::CMD_LOAD_ROW;
    in_ch.row_index = 2'd0;
    in_ch.elem_a    = '0;
    in_ch.elem_b    = '0;
    in_ch.elem_c    = '0;
    in_ch.elem_d    = '0;
    out_ch.ready    = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    send_idle_pct   = 34;
    recv_idle_pct   = 56;
    reset_matrix();

    // hold reset, then release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_identity_reset();
    test_extreme_rows();
    test_point_translation();
    test_rounding();
    test_unused_command();
    test_random_traffic(450);

    send_idle_pct = 56;
    recv_idle_pct = 34;
    test_random_traffic(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(450);

    // drain outstanding transforms, then watch for strays
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
